// ----- rtl/bzseq_pkg.sv -----
// ----------------------------------------------------------------------------
// bzseq_pkg
// Types and constants shared by the buzzer tune sequencer: transfer payloads,
// command codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package bzseq_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TUNE_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_FREQUENCY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQUENCY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIVIDER     = 3'd4;

    // register reset values
    localparam logic [15:0] TEMPO_RST           = 16'd500;
    localparam logic [6:0]  TUNE_LENGTH_RST     = 7'd0;
    localparam logic [28:0] CLOCK_FREQUENCY_RST = 29'd80000000;
    localparam logic [15:0] MIN_FREQUENCY_RST   = 16'd40;
    localparam logic [14:0] MAX_DIVIDER_RST     = 15'd64;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_BEEP  = 2'd3;

    // shared divider: 24-bit dividend, 17-bit divisor
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 17;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         note_index;
        logic [15:0]        note_frequency;
        logic signed [15:0] note_duration;
    } in_t;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_period;
        logic        playing;
        logic [6:0]  note_position;
    } out_t;

endpackage

// ----- rtl/buzzer_tune_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// buzzer_tune_sequencer_unit
// Tick-driven melody player: note store, playback sequencer and one shared
// restoring divider for tone period and note duration.
// ----------------------------------------------------------------------------
// Tick with running countdown, note write and start pass ST_OUT to the output
//   register; playing a note also runs ST_NOTE, the dividers and ST_DUR.
// Throughput: one item at a time; a played note runs the shared 24-step
//   divider up to twice (tone period, then duration), one quotient bit per cycle.
// Reset: configuration registers load their defaults, playback stopped,
//   tone off; note store contents are undefined until written.
module buzzer_tune_sequencer_unit #(
    parameter int TUNE_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [bzseq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bzseq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  bzseq_pkg::in_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bzseq_pkg::out_t                      out_data
);
    import bzseq_pkg::*;

    localparam int AW = $clog2(TUNE_DEPTH);
    localparam int CNT_W = $clog2(DIV_NUM_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_NOTE  = 3'd2;
    localparam logic [2:0] ST_PDIV  = 3'd3;
    localparam logic [2:0] ST_DUR   = 3'd4;
    localparam logic [2:0] ST_CDIV  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // configuration
    logic [15:0] tempo_reg;
    logic [6:0]  tune_length_reg;
    logic [28:0] clock_frequency_reg;
    logic [15:0] min_frequency_reg;
    logic [14:0] max_divider_reg;

    // player state
    logic [2:0]  state_reg, state_next;
    logic [15:0] countdown_reg, countdown_next;
    logic        active_reg, active_next;
    logic [6:0]  position_reg, position_next;
    logic        tone_running_reg, tone_running_next;
    logic [15:0] period_value_reg, period_value_next;
    logic [15:0] note_f_reg, note_f_next;
    logic [15:0] note_d_reg, note_d_next;

    // shared divider
    logic [DIV_NUM_W-1:0] div_num_reg, div_num_next;
    logic [DIV_DEN_W-1:0] div_den_reg, div_den_next;
    logic [DIV_DEN_W-1:0] div_rem_reg, div_rem_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [DIV_DEN_W:0]   div_trial;
    logic                 div_bit;
    logic [DIV_DEN_W-1:0] div_rem_step;
    logic [DIV_NUM_W-1:0] div_q_step;
    logic [15:0]          div_q_sat;

    // output register
    logic  out_valid_reg, out_valid_next;
    out_t  out_data_reg, out_data_next;

    // note store
    logic [31:0] mem [TUNE_DEPTH];
    logic [31:0] mem_rd_reg;
    logic        mem_we;

    logic        in_xfer;
    logic [15:0] freq_clamped;
    logic [15:0] dot_mag;
    logic [17:0] tempo_x3;
    logic        can_play;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign mem_we = in_xfer && (in_data.command == CMD_WRITE)
                    && (32'(in_data.note_index) < TUNE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(in_data.note_index)] <= {in_data.note_frequency, in_data.note_duration};
        end
        mem_rd_reg <= mem[AW'(position_reg)];
    end

    // one restoring division step
    assign div_trial    = {div_rem_reg, div_num_reg[DIV_NUM_W-1]};
    assign div_bit      = (div_trial >= {1'b0, div_den_reg});
    assign div_rem_step = div_bit ? DIV_DEN_W'(div_trial - {1'b0, div_den_reg})
                                  : div_trial[DIV_DEN_W-1:0];
    assign div_q_step   = {div_num_reg[DIV_NUM_W-2:0], div_bit};
    assign div_q_sat    = (div_q_step[DIV_NUM_W-1:16] != '0) ? 16'hFFFF : div_q_step[15:0];

    assign freq_clamped = (note_f_reg < min_frequency_reg) ? min_frequency_reg : note_f_reg;
    assign dot_mag      = 16'(~note_d_reg + 16'd1);
    assign tempo_x3     = {1'b0, tempo_reg, 1'b0} + {2'b00, tempo_reg};
    assign can_play     = active_reg && (position_reg < tune_length_reg)
                          && (32'(position_reg) < TUNE_DEPTH);

    always_comb
    begin
        state_next        = state_reg;
        countdown_next    = countdown_reg;
        active_next       = active_reg;
        position_next     = position_reg;
        tone_running_next = tone_running_reg;
        period_value_next = period_value_reg;
        note_f_next       = note_f_reg;
        note_d_next       = note_d_reg;
        div_num_next      = div_num_reg;
        div_den_next      = div_den_reg;
        div_rem_next      = div_rem_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_data_next     = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_OUT;
                    case (in_data.command)
                        CMD_TICK:
                        begin
                            if (countdown_reg != 16'd0)
                            begin
                                countdown_next = countdown_reg - 16'd1;
                            end
                            else if (can_play)
                            begin
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                position_next     = 7'd0;
                                active_next       = 1'b0;
                                tone_running_next = 1'b0;
                            end
                        end
                        CMD_WRITE:
                        begin
                            state_next = ST_OUT;
                        end
                        CMD_START:
                        begin
                            position_next = 7'd0;
                            active_next   = 1'b1;
                        end
                        default:
                        begin
                            note_f_next = in_data.note_frequency;
                            note_d_next = in_data.note_duration;
                            state_next  = ST_NOTE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                note_f_next   = mem_rd_reg[31:16];
                note_d_next   = mem_rd_reg[15:0];
                position_next = position_reg + 7'd1;
                state_next    = ST_NOTE;
            end
            ST_NOTE:
            begin
                if (note_f_reg == 16'd0)
                begin
                    tone_running_next = 1'b0;
                    state_next        = ST_DUR;
                end
                else
                begin
                    // clock / (32 * f) == (clock >> 5) / f
                    div_num_next = clock_frequency_reg[28:5];
                    div_den_next = {1'b0, freq_clamped};
                    div_rem_next = '0;
                    div_cnt_next = CNT_W'(DIV_NUM_W - 1);
                    state_next   = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                div_num_next = div_q_step;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    period_value_next = div_q_sat;
                    tone_running_next = 1'b1;
                    state_next        = ST_DUR;
                end
            end
            ST_DUR:
            begin
                div_rem_next = '0;
                div_cnt_next = CNT_W'(DIV_NUM_W - 1);
                if (note_d_reg == 16'd0)
                begin
                    countdown_next = 16'd0;
                    state_next     = ST_OUT;
                end
                else if (!note_d_reg[15])
                begin
                    if (note_d_reg[14:0] <= max_divider_reg)
                    begin
                        div_num_next = DIV_NUM_W'(tempo_reg);
                        div_den_next = DIV_DEN_W'(note_d_reg);
                        state_next   = ST_CDIV;
                    end
                    else
                    begin
                        // above max divider: duration in milliseconds
                        countdown_next = note_d_reg;
                        state_next     = ST_OUT;
                    end
                end
                else
                begin
                    // dotted note: 3 * tempo / (2 * |d|)
                    div_num_next = DIV_NUM_W'(tempo_x3);
                    div_den_next = {dot_mag, 1'b0};
                    state_next   = ST_CDIV;
                end
            end
            ST_CDIV:
            begin
                div_num_next = div_q_step;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    countdown_next = div_q_sat;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.tone_on       = tone_running_reg;
                    out_data_next.tone_period   = tone_running_reg ? period_value_reg : 16'd0;
                    out_data_next.playing       = active_reg;
                    out_data_next.note_position = position_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg           <= TEMPO_RST;
            tune_length_reg     <= TUNE_LENGTH_RST;
            clock_frequency_reg <= CLOCK_FREQUENCY_RST;
            min_frequency_reg   <= MIN_FREQUENCY_RST;
            max_divider_reg     <= MAX_DIVIDER_RST;
            state_reg           <= ST_IDLE;
            countdown_reg       <= 16'd0;
            active_reg          <= 1'b0;
            position_reg        <= 7'd0;
            tone_running_reg    <= 1'b0;
            period_value_reg    <= 16'd0;
            div_cnt_reg         <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TEMPO:           tempo_reg           <= cfg_data[15:0];
                    REG_TUNE_LENGTH:     tune_length_reg     <= cfg_data[6:0];
                    REG_CLOCK_FREQUENCY: clock_frequency_reg <= cfg_data[28:0];
                    REG_MIN_FREQUENCY:   min_frequency_reg   <= cfg_data[15:0];
                    REG_MAX_DIVIDER:     max_divider_reg     <= cfg_data[14:0];
                    default:             ;
                endcase
            end
            state_reg        <= state_next;
            countdown_reg    <= countdown_next;
            active_reg       <= active_next;
            position_reg     <= position_next;
            tone_running_reg <= tone_running_next;
            period_value_reg <= period_value_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        note_f_reg   <= note_f_next;
        note_d_reg   <= note_d_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
        div_rem_reg  <= div_rem_next;
        out_data_reg <= out_data_next;
    end

    // every transfer takes the sequencer out of idle in the next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("accepted item did not occupy the sequencer");

    // playback stopped always leaves the position at the start
    a_idle_position: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (position_reg == 7'd0))
        else $error("position nonzero while not playing");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(position_reg) <= TUNE_DEPTH)
        else $error("position beyond note store");

    // silent tone shows zero period
    a_silent_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.tone_on || (out_data_reg.tone_period == 16'd0)))
        else $error("period shown while tone is off");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buzzer tune sequencer testbench
// Drives note writes, tune starts, single beeps and ticks over the valid/ready
// input channel. A behavioral copy of the player predicts every result, and
// each result transfer is compared field by field against the oldest
// prediction. Configuration is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
    import bzseq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 60;
    localparam int LONG_COUNT   = 200;
    localparam int PRINT_CAP    = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;

    // player state as the testbench sees it
    logic [15:0] cfg_tempo;
    logic [6:0]  cfg_length;
    logic [28:0] cfg_clock;
    logic [15:0] cfg_min_freq;
    logic [14:0] cfg_max_div;
    logic [15:0] tick_count;
    logic        playback_on;
    logic        buzz_on;
    logic [6:0]  next_pos;
    logic [15:0] half_period;
    logic [15:0] freq_mem [DEPTH];
    logic [15:0] dur_mem [DEPTH];

    out_t expected_tones [$];

    int  items_sent      = 0;
    int  results_checked = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    int  notes_played    = 0;
    int  beeps_sent      = 0;
    int  starts_sent     = 0;
    int  stall_left      = 0;
    bit  quiet           = 1'b0;

    buzzer_tune_sequencer_unit #(
        .TUNE_DEPTH(DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // player prediction
    // ------------------------------------------------------------------
    function automatic void reset_player();
        cfg_tempo    = TEMPO_RST;
        cfg_length   = TUNE_LENGTH_RST;
        cfg_clock    = CLOCK_FREQUENCY_RST;
        cfg_min_freq = MIN_FREQUENCY_RST;
        cfg_max_div  = MAX_DIVIDER_RST;
        tick_count   = '0;
        playback_on  = 1'b0;
        buzz_on      = 1'b0;
        next_pos     = '0;
        half_period  = '0;
    endfunction

    function automatic void sound_note(logic [15:0] freq, logic [15:0] dur);
        longint unsigned f;
        longint unsigned q;
        longint unsigned t;
        longint unsigned m;
        if (freq == 16'd0)
        begin
            // silence keeps the last period
            buzz_on = 1'b0;
        end
        else
        begin
            f = (freq < cfg_min_freq) ? cfg_min_freq : freq;
            q = cfg_clock / (32 * f);
            half_period = (q > 65535) ? 16'hFFFF : q[15:0];
            buzz_on = 1'b1;
        end
        if (dur == 16'd0)
            tick_count = '0;
        else if (!dur[15])
            tick_count = (dur <= cfg_max_div) ? cfg_tempo / dur : dur;
        else
        begin
            // dotted note: one and a half of tempo over the magnitude
            t = cfg_tempo;
            m = 17'h10000 - {1'b0, dur};
            q = (t * 3) / (2 * m);
            tick_count = (q > 65535) ? 16'hFFFF : q[15:0];
        end
    endfunction

    function automatic out_t advance_player(in_t item);
        out_t r;
        case (item.command)
            CMD_TICK:
            begin
                if (tick_count != 16'd0)
                    tick_count = tick_count - 16'd1;
                else if (playback_on && next_pos < cfg_length && next_pos < DEPTH)
                begin
                    sound_note(freq_mem[next_pos[5:0]], dur_mem[next_pos[5:0]]);
                    next_pos = next_pos + 7'd1;
                    notes_played++;
                end
                else
                begin
                    next_pos    = '0;
                    playback_on = 1'b0;
                    buzz_on     = 1'b0;
                end
            end
            CMD_WRITE:
            begin
                if (item.note_index < DEPTH)
                begin
                    freq_mem[item.note_index] = item.note_frequency;
                    dur_mem[item.note_index]  = item.note_duration;
                end
            end
            CMD_START:
            begin
                next_pos    = '0;
                playback_on = 1'b1;
            end
            CMD_BEEP:
            begin
                sound_note(item.note_frequency, item.note_duration);
            end
            default: ;
        endcase
        r.tone_on       = buzz_on;
        r.tone_period   = buzz_on ? half_period : 16'd0;
        r.playing       = playback_on;
        r.note_position = next_pos;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_t make_item(logic [1:0] cmd, logic [5:0] idx,
                                      logic [15:0] freq, logic [15:0] dur);
        in_t item;
        item.command        = cmd;
        item.note_index     = idx;
        item.note_frequency = freq;
        item.note_duration  = dur;
        return item;
    endfunction

    function automatic logic [15:0] pick_freq();
        int roll;
        int top;
        roll = $urandom_range(0, 7);
        top  = int'(cfg_min_freq) + 50;
        if (top > 65535)
            top = 65535;
        if (roll == 0)
            return 16'd0;
        if (roll < 3)
            return 16'($urandom_range(1, top));
        return 16'($urandom);
    endfunction

    // mostly short countdowns so that tunes make progress
    function automatic logic [15:0] pick_duration();
        int roll;
        int v;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return 16'd0;
            1, 2, 3: return 16'($urandom_range(1, (cfg_max_div == 0) ? 1 : cfg_max_div));
            4, 5:
            begin
                v = int'(cfg_max_div) + $urandom_range(1, 20);
                if (v > 32767)
                    v = 32767;
                return 16'(v);
            end
            6, 7: return 16'(0 - $urandom_range(1, 8));
            8: return 16'($urandom);
            default: return 16'd1;
        endcase
    endfunction

    function automatic in_t note_write();
        int hi;
        logic [5:0] idx;
        hi = (cfg_length > DEPTH) ? DEPTH : cfg_length;
        if (hi > 0 && $urandom_range(0, 9) < 7)
            idx = 6'($urandom_range(0, hi - 1));
        else
            idx = 6'($urandom);
        return make_item(CMD_WRITE, idx, pick_freq(), pick_duration());
    endfunction

    function automatic in_t noise_item();
        return make_item(2'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // called at a rising edge; returns at the edge that accepts the transfer
    task automatic send_item(input in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_tones.push_back(advance_player(item));
        items_sent++;
        if (item.command == CMD_BEEP)
            beeps_sent++;
        if (item.command == CMD_START)
            starts_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_tones.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            REG_TEMPO:           cfg_tempo    = 16'(value);
            REG_TUNE_LENGTH:     cfg_length   = 7'(value);
            REG_CLOCK_FREQUENCY: cfg_clock    = 29'(value);
            REG_MIN_FREQUENCY:   cfg_min_freq = 16'(value);
            REG_MAX_DIVIDER:     cfg_max_div  = 15'(value);
            default: ;
        endcase
    endtask

    task automatic set_registers(input int unsigned tempo_v, input int unsigned length_v,
                                 input int unsigned clock_v, input int unsigned minf_v,
                                 input int unsigned maxd_v);
        wait_idle();
        write_reg(REG_TEMPO, tempo_v);
        write_reg(REG_TUNE_LENGTH, length_v);
        write_reg(REG_CLOCK_FREQUENCY, clock_v);
        write_reg(REG_MIN_FREQUENCY, minf_v);
        write_reg(REG_MAX_DIVIDER, maxd_v);
        cfg_wr_en <= 1'b0;
    endtask

    // start the tune and tick through it; a long countdown is cut short by a beep
    task automatic play_tune(input int budget, input bit mixed);
        int roll;
        send_item(make_item(CMD_START, 6'($urandom), 16'($urandom), 16'($urandom)));
        for (int n = 0; n < budget && playback_on; n++)
        begin
            roll = $urandom_range(0, 99);
            if (tick_count > LONG_COUNT)
                send_item(make_item(CMD_BEEP, 6'($urandom), pick_freq(), 16'd0));
            else if (mixed && roll < 3)
                send_item(make_item(CMD_START, 6'($urandom), 16'($urandom), 16'($urandom)));
            else if (mixed && roll < 7)
                send_item(make_item(CMD_BEEP, 6'($urandom), pick_freq(), pick_duration()));
            else if (mixed && roll < 10)
                send_item(note_write());
            else
                send_item(make_item(CMD_TICK, 6'($urandom), 16'($urandom), 16'($urandom)));
        end
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    task automatic test_idle_tick();
        // tick after reset stops, start with an empty tune ends on the next tick
        send_item(make_item(CMD_TICK, '0, '0, '0));
        send_item(make_item(CMD_START, '1, '1, '1));
        send_item(make_item(CMD_TICK, '1, '1, '1));
    endtask

    task automatic test_store_fill();
        send_item(make_item(CMD_WRITE, 6'd0, 16'hFFFF, 16'h8000));
        for (int i = 1; i < DEPTH - 1; i++)
            send_item(make_item(CMD_WRITE, 6'(i), pick_freq(), pick_duration()));
        send_item(make_item(CMD_WRITE, 6'd63, 16'd0, 16'h7FFF));
    endtask

    task automatic test_single_beep();
        logic [15:0] freqs [10];
        logic [15:0] durs [10];
        freqs = '{16'd0, 16'd1, 16'd39, 16'd40, 16'hFFFF,
                  16'd1000, 16'd440, 16'd440, 16'd0, 16'd2000};
        durs  = '{16'd0, 16'd1, 16'd0, 16'd64, 16'd65,
                  16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFD, 16'd0};
        for (int i = 0; i < 10; i++)
        begin
            send_item(make_item(CMD_BEEP, 6'($urandom), freqs[i], durs[i]));
            send_item(make_item(CMD_TICK, '0, '0, '0));
        end
    endtask

    task automatic test_tune_start();
        set_registers(8, 3, CLOCK_FREQUENCY_RST, MIN_FREQUENCY_RST, 4);
        send_item(make_item(CMD_START, '0, '0, '0));
        send_item(make_item(CMD_TICK, '0, '0, '0));
        // restart while running keeps the countdown
        play_tune(60, 1'b0);
    endtask

    task automatic test_config_extremes();
        set_registers(0, 64, 400000000, 1, 1);
        play_tune(300, 1'b1);
        send_item(make_item(CMD_BEEP, '0, 16'd1, 16'd1));
        // length past the store depth, one-hertz clock, highest floor
        set_registers(65535, 127, 1, 65535, 32767);
        play_tune(400, 1'b1);
        send_item(make_item(CMD_BEEP, '0, 16'hFFFF, 16'hFFFF));
        send_item(make_item(CMD_BEEP, '0, 16'd1, 16'd0));
        // zero frequency floor
        set_registers(3, 1, 80000000, 0, 5);
        play_tune(40, 1'b1);
        send_item(make_item(CMD_BEEP, '0, 16'd1, 16'd6));
        send_item(make_item(CMD_BEEP, '0, 16'd0, 16'd0));
    endtask

    task automatic test_random_play();
        int first;
        int roll;
        int unsigned t, ln, ck, mf, md;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            t  = (roll < 70) ? $urandom_range(0, 40)
               : (roll < 85) ? $urandom_range(41, 2000) : $urandom_range(0, 65535);
            roll = $urandom_range(0, 99);
            ln = (roll < 60) ? $urandom_range(1, 12)
               : (roll < 80) ? $urandom_range(13, 64)
               : (roll < 90) ? 0 : $urandom_range(65, 127);
            ck = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5000)
                                             : $urandom_range(1, 400000000);
            roll = $urandom_range(0, 99);
            mf = (roll < 60) ? $urandom_range(1, 500)
               : (roll < 90) ? $urandom_range(1, 65535) : 0;
            md = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(1, 32767);
            set_registers(t, ln, ck, mf, md);
            quiet = ($urandom_range(0, 7) == 0);
            repeat ($urandom_range(3, 8))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(note_write());
                end
                else if (roll < 80)
                    play_tune(80, 1'b1);
                else
                begin
                    repeat ($urandom_range(1, 5))
                        send_item(noise_item());
                end
            end
            quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (roll < 20)
        begin
            stall_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else if (roll < 23)
        begin
            stall_left = $urandom_range(8, 25);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tones.size() == 0)
                report_mismatch("result transfer with none expected", out_data, 0);
            else
            begin
                want = expected_tones.pop_front();
                results_checked++;
                if (out_data.tone_on !== want.tone_on)
                    report_mismatch("tone_on", out_data.tone_on, want.tone_on);
                if (out_data.tone_period !== want.tone_period)
                    report_mismatch("tone_period", out_data.tone_period, want.tone_period);
                if (out_data.playing !== want.playing)
                    report_mismatch("playing", out_data.playing, want.playing);
                if (out_data.note_position !== want.note_position)
                    report_mismatch("note_position", out_data.note_position,
                                    want.note_position);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_tones.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_player();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_tick();
        test_store_fill();
        test_single_beep();
        test_tune_start();
        test_config_extremes();
        test_random_play();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_tones.size() != 0)
            report_mismatch("results never delivered", expected_tones.size(), 0);

        $display("sent %0d transfers: %0d notes played from the store, %0d beeps, %0d starts",
                 items_sent, notes_played, beeps_sent, starts_sent);
        $display("checked %0d results, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
